>>> rtl/gdfs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// Package for the grid maze depth-first search solver.
// Holds grid sizes, cell and config types, the controller states and the
// command/status structs between controller and datapath. No dependencies.
package gdfs_pkg;

  // Grid bounds
  localparam int MAX_ROWS = 8;
  localparam int MAX_COLS = 8;

  // Field widths (fixed by the item format)
  localparam int ROW_W   = 3;
  localparam int COL_W   = 3;
  localparam int CNT_W   = 4;                 // rows_in_use / cols_in_use
  localparam int CELL_W  = ROW_W + COL_W;
  localparam int CELLS   = 2 ** CELL_W;
  localparam int DEPTH_W = CELL_W + 1;        // stack depth, holds CELLS
  localparam int DIR_W   = 2;

  // Configuration port
  localparam int CFG_AW = 5;
  localparam int CFG_DW = 32;
  localparam int CFG_IW = 3;                  // register index bits

  localparam logic [CFG_IW-1:0] REG_ROWS      = 3'd0;
  localparam logic [CFG_IW-1:0] REG_COLS      = 3'd1;
  localparam logic [CFG_IW-1:0] REG_START_ROW = 3'd2;
  localparam logic [CFG_IW-1:0] REG_START_COL = 3'd3;
  localparam logic [CFG_IW-1:0] REG_EXIT_ROW  = 3'd4;
  localparam logic [CFG_IW-1:0] REG_EXIT_COL  = 3'd5;

  // Item opcodes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_SOLVE = 1'b1;

  // Neighbor order
  localparam logic [DIR_W-1:0] DIR_UP    = 2'd0;
  localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd1;
  localparam logic [DIR_W-1:0] DIR_DOWN  = 2'd2;
  localparam logic [DIR_W-1:0] DIR_LEFT  = 2'd3;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } cell_t;

  typedef struct packed {
    logic [DIR_W-1:0] dir;
    cell_t            pos;
  } stack_ent_t;

  typedef struct packed {
    logic [CNT_W-1:0] rows_in_use;
    logic [CNT_W-1:0] cols_in_use;
    logic [ROW_W-1:0] start_row;
    logic [COL_W-1:0] start_col;
    logic [ROW_W-1:0] exit_row;
    logic [COL_W-1:0] exit_col;
  } cfg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_PROBE,
    S_CHECK,
    S_PATH,
    S_PWAIT,
    S_FAIL
  } state_t;

  typedef struct packed {
    logic wall_we;
    logic init;
    logic probe;
    logic check;
    logic path_emit;
    logic path_next;
    logic fail_emit;
  } dp_cmd_t;

  typedef struct packed {
    logic start_out;
    logic found;
    logic exhausted;
    logic at_start;
    logic out_free;
  } dp_stat_t;

endpackage
`default_nettype wire

>>> rtl/gdfs_if.sv
`timescale 1ns / 1ps
`default_nettype none
// Valid/ready channel interfaces for the maze solver's input and result items.
// Depends on gdfs_pkg for field widths.
interface gdfs_in_if import gdfs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             opcode;
  logic [ROW_W-1:0] cell_row;
  logic [COL_W-1:0] cell_col;
  logic             is_wall;

  modport source (output valid, output opcode, output cell_row, output cell_col,
                  output is_wall, input ready);
  modport sink   (input valid, input opcode, input cell_row, input cell_col,
                  input is_wall, output ready);
endinterface

interface gdfs_out_if import gdfs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             found;
  logic [ROW_W-1:0] path_row;
  logic [COL_W-1:0] path_col;
  logic             last;

  modport source (output valid, output found, output path_row, output path_col,
                  output last, input ready);
  modport sink   (input valid, input found, input path_row, input path_col,
                  input last, output ready);
endinterface
`default_nettype wire

>>> rtl/gdfs_cfg.sv
`timescale 1ns / 1ps
`default_nettype none
// APB-style configuration registers: grid size, start and exit cells.
// Depends on gdfs_pkg.
module gdfs_cfg import gdfs_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [CFG_AW-1:0] cfg_paddr,
  input  wire logic [CFG_DW-1:0] cfg_pwdata,
  output logic      [CFG_DW-1:0] cfg_prdata,
  output logic                   cfg_pready,
  output cfg_t                   cfg
);

  cfg_t              cfg_r, cfg_nxt;
  logic              wr_en;
  logic [CFG_IW-1:0] idx;

  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite;
  assign idx        = cfg_paddr[CFG_AW-1:2];
  assign cfg_pready = 1'b1;
  assign cfg        = cfg_r;

  // register write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_ROWS:      cfg_nxt.rows_in_use = cfg_pwdata[CNT_W-1:0];
        REG_COLS:      cfg_nxt.cols_in_use = cfg_pwdata[CNT_W-1:0];
        REG_START_ROW: cfg_nxt.start_row   = cfg_pwdata[ROW_W-1:0];
        REG_START_COL: cfg_nxt.start_col   = cfg_pwdata[COL_W-1:0];
        REG_EXIT_ROW:  cfg_nxt.exit_row    = cfg_pwdata[ROW_W-1:0];
        REG_EXIT_COL:  cfg_nxt.exit_col    = cfg_pwdata[COL_W-1:0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rows_in_use <= CNT_W'(MAX_ROWS);
      cfg_r.cols_in_use <= CNT_W'(MAX_COLS);
      cfg_r.start_row   <= '0;
      cfg_r.start_col   <= '0;
      cfg_r.exit_row    <= ROW_W'(MAX_ROWS - 1);
      cfg_r.exit_col    <= COL_W'(MAX_COLS - 1);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // read mux
  always_comb begin
    unique case (idx)
      REG_ROWS:      cfg_prdata = CFG_DW'(cfg_r.rows_in_use);
      REG_COLS:      cfg_prdata = CFG_DW'(cfg_r.cols_in_use);
      REG_START_ROW: cfg_prdata = CFG_DW'(cfg_r.start_row);
      REG_START_COL: cfg_prdata = CFG_DW'(cfg_r.start_col);
      REG_EXIT_ROW:  cfg_prdata = CFG_DW'(cfg_r.exit_row);
      REG_EXIT_COL:  cfg_prdata = CFG_DW'(cfg_r.exit_col);
      default:       cfg_prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/gdfs_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// Controller state machine of the maze solver: sequences load, search steps,
// path walk and failure result. Depends on gdfs_pkg.
module gdfs_ctrl import gdfs_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  input  wire logic     in_opcode,
  output logic          in_ready,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_opcode == OP_LOAD) cmd.wall_we = 1'b1;
          else                      state_nxt = S_START;
        end
      end
      S_START: begin
        if (stat.start_out) begin
          state_nxt = S_FAIL;
        end else begin
          cmd.init  = 1'b1;
          state_nxt = S_PROBE;
        end
      end
      S_PROBE: begin
        cmd.probe = 1'b1;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        if (stat.found)          state_nxt = S_PATH;
        else if (stat.exhausted) state_nxt = S_FAIL;
        else                     state_nxt = S_PROBE;
      end
      S_PATH: begin
        if (stat.out_free) begin
          cmd.path_emit = 1'b1;
          state_nxt     = stat.at_start ? S_IDLE : S_PWAIT;
        end
      end
      S_PWAIT: begin
        cmd.path_next = 1'b1;
        state_nxt     = S_PATH;
      end
      S_FAIL: begin
        if (stat.out_free) begin
          cmd.fail_emit = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/gdfs_dpath.sv
`timescale 1ns / 1ps
`default_nettype none
// Datapath of the maze solver: wall, parent and stack memories, visited bits,
// top-of-stack and neighbor probe registers, result register. Depends on gdfs_pkg.
module gdfs_dpath import gdfs_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire cfg_t             cfg,
  input  wire dp_cmd_t          cmd,
  output dp_stat_t              stat,
  input  wire logic [ROW_W-1:0] in_cell_row,
  input  wire logic [COL_W-1:0] in_cell_col,
  input  wire logic             in_is_wall,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic                  out_found,
  output logic      [ROW_W-1:0] out_path_row,
  output logic      [COL_W-1:0] out_path_col,
  output logic                  out_last
);

  // memories
  logic       wall_mem   [CELLS];
  cell_t      parent_mem [CELLS];
  stack_ent_t stack_mem  [CELLS];

  logic [CELLS-1:0]   wall_vld_r;
  logic [CELLS-1:0]   visited_r;
  logic               wall_bit_r, wall_vbit_r;
  stack_ent_t         stack_rd_r;
  cell_t              parent_rd_r;

  cell_t              top_cell_r;
  logic [DIR_W-1:0]   top_dir_r;
  logic [DEPTH_W-1:0] depth_r;

  cell_t              pr_cell_r, pr_nb_r;
  logic               pr_ok_r, pr_pop_r, pr_exit_r;
  cell_t              cur_r;

  logic               out_valid_r, out_found_r, out_last_r;
  cell_t              out_cell_r;

  // effective grid size, saturated at the maximum
  logic [CNT_W-1:0] nr, nc;
  assign nr = (cfg.rows_in_use > CNT_W'(MAX_ROWS)) ? CNT_W'(MAX_ROWS) : cfg.rows_in_use;
  assign nc = (cfg.cols_in_use > CNT_W'(MAX_COLS)) ? CNT_W'(MAX_COLS) : cfg.cols_in_use;

  cell_t start_cell;
  assign start_cell = '{row: cfg.start_row, col: cfg.start_col};

  // neighbor of the top entry in its current direction
  logic [CNT_W-1:0] rr, cc;
  logic             nb_ok, nb_exit;
  cell_t            nb;
  always_comb begin
    rr    = CNT_W'(top_cell_r.row);
    cc    = CNT_W'(top_cell_r.col);
    nb_ok = 1'b1;
    unique case (top_dir_r)
      DIR_UP: begin
        if (top_cell_r.row == '0) nb_ok = 1'b0;
        else                      rr = CNT_W'(top_cell_r.row) - CNT_W'(1);
      end
      DIR_RIGHT: cc = CNT_W'(top_cell_r.col) + CNT_W'(1);
      DIR_DOWN:  rr = CNT_W'(top_cell_r.row) + CNT_W'(1);
      DIR_LEFT: begin
        if (top_cell_r.col == '0) nb_ok = 1'b0;
        else                      cc = CNT_W'(top_cell_r.col) - CNT_W'(1);
      end
      default: nb_ok = 1'b0;
    endcase
    nb_ok   = nb_ok && (rr < nr) && (cc < nc);
    nb      = '{row: rr[ROW_W-1:0], col: cc[COL_W-1:0]};
    nb_exit = (rr[ROW_W-1:0] == cfg.exit_row) && (cc[COL_W-1:0] == cfg.exit_col);
  end

  // stack addresses: entry below the top, and the top's own slot
  logic [DEPTH_W-1:0] below_d, top_d;
  logic [CELL_W-1:0]  below_a, top_a;
  assign below_d = depth_r - DEPTH_W'(2);
  assign top_d   = depth_r - DEPTH_W'(1);
  assign below_a = below_d[CELL_W-1:0];
  assign top_a   = top_d[CELL_W-1:0];

  // check-stage outcome
  logic accept;
  assign accept = pr_ok_r & ~(wall_bit_r & wall_vbit_r) & ~visited_r[pr_nb_r];

  // load bounds
  logic load_in;
  assign load_in = (CNT_W'(in_cell_row) < CNT_W'(MAX_ROWS)) &&
                   (CNT_W'(in_cell_col) < CNT_W'(MAX_COLS));
  cell_t load_cell;
  assign load_cell = '{row: in_cell_row, col: in_cell_col};

  // wall memory and its valid bits (unwritten cells read open)
  always_ff @(posedge clk) begin
    if (cmd.wall_we && load_in) wall_mem[load_cell] <= in_is_wall;
    wall_bit_r <= wall_mem[nb];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wall_vld_r  <= '0;
      wall_vbit_r <= 1'b0;
    end else begin
      if (cmd.wall_we && load_in) wall_vld_r[load_cell] <= 1'b1;
      wall_vbit_r <= wall_vld_r[nb];
    end
  end

  // parent memory
  always_ff @(posedge clk) begin
    if (cmd.check && accept) parent_mem[pr_nb_r] <= pr_cell_r;
    parent_rd_r <= parent_mem[cur_r];
  end

  // stack memory holds every entry below the top
  always_ff @(posedge clk) begin
    if (cmd.check && accept && !pr_exit_r && !pr_pop_r)
      stack_mem[top_a] <= '{dir: top_dir_r, pos: top_cell_r};
    stack_rd_r <= stack_mem[below_a];
  end

  // visited bits and stack depth
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      visited_r <= '0;
      depth_r   <= '0;
    end else if (cmd.init) begin
      visited_r <= CELLS'(1) << start_cell;
      depth_r   <= DEPTH_W'(1);
    end else if (cmd.check) begin
      if (accept) begin
        visited_r[pr_nb_r] <= 1'b1;
        if (!pr_exit_r && !pr_pop_r) depth_r <= depth_r + DEPTH_W'(1);
      end else if (pr_pop_r) begin
        depth_r <= depth_r - DEPTH_W'(1);
      end
    end
  end

  // top-of-stack, probe registers, path cursor
  always_ff @(posedge clk) begin
    if (cmd.init) begin
      top_cell_r <= start_cell;
      top_dir_r  <= DIR_UP;
    end else if (cmd.probe) begin
      pr_cell_r <= top_cell_r;
      pr_nb_r   <= nb;
      pr_ok_r   <= nb_ok;
      pr_pop_r  <= (top_dir_r == DIR_LEFT);
      pr_exit_r <= nb_exit;
      if (top_dir_r != DIR_LEFT) top_dir_r <= top_dir_r + DIR_W'(1);
    end else if (cmd.check) begin
      if (accept) begin
        if (pr_exit_r) begin
          cur_r <= pr_nb_r;
        end else begin
          top_cell_r <= pr_nb_r;
          top_dir_r  <= DIR_UP;
        end
      end else if (pr_pop_r) begin
        top_cell_r <= stack_rd_r.pos;
        top_dir_r  <= stack_rd_r.dir;
      end
    end else if (cmd.path_next) begin
      cur_r <= parent_rd_r;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.path_emit || cmd.fail_emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.path_emit) begin
      out_found_r <= 1'b1;
      out_cell_r  <= cur_r;
      out_last_r  <= (cur_r == start_cell);
    end else if (cmd.fail_emit) begin
      out_found_r <= 1'b0;
      out_cell_r  <= '0;
      out_last_r  <= 1'b1;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_found    = out_found_r;
  assign out_path_row = out_cell_r.row;
  assign out_path_col = out_cell_r.col;
  assign out_last     = out_last_r;

  // status to the controller
  assign stat.start_out = (CNT_W'(cfg.start_row) >= nr) || (CNT_W'(cfg.start_col) >= nc);
  assign stat.found     = accept & pr_exit_r;
  assign stat.exhausted = ~accept & pr_pop_r & (depth_r == DEPTH_W'(1));
  assign stat.at_start  = (cur_r == start_cell);
  assign stat.out_free  = ~out_valid_r | out_ready;

endmodule
`default_nettype wire

>>> rtl/grid_maze_dfs_solver.sv
`timescale 1ns / 1ps
`default_nettype none
// Top level of the grid maze depth-first search solver.
// Depends on gdfs_pkg, gdfs_if, gdfs_cfg, gdfs_ctrl and gdfs_dpath.
//
//  channel   direction  handshake              payload
//  in_ch     in         valid/ready            opcode, cell_row, cell_col, is_wall
//  out_ch    out        valid/ready            found, path_row, path_col, last
//  cfg_*     in         APB write, pready=1    six config registers at 4*i
//
// Loads stream back to back. A solve runs a start state, then per search
// step a probe state and then a wall/visited check state (set by the registered
// wall and stack memory reads), then per path cell an emit state and, for
// each cell before the start cell, a wait state for the parent memory read,
// plus output stalls.
// Reset (rst_n low, synchronous) opens all walls and clears the visited bits
// at once; no clearing pass. Input is taken only while the sequencer is idle;
// a held result stalls the path walk.
module grid_maze_dfs_solver import gdfs_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  gdfs_in_if.sink                in_ch,
  gdfs_out_if.source             out_ch,
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [CFG_AW-1:0] cfg_paddr,
  input  wire logic [CFG_DW-1:0] cfg_pwdata,
  output logic      [CFG_DW-1:0] cfg_prdata,
  output logic                   cfg_pready
);

  cfg_t     cfg;
  dp_cmd_t  cmd;
  dp_stat_t stat;

  gdfs_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  gdfs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_opcode (in_ch.opcode),
    .in_ready  (in_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  gdfs_dpath u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg),
    .cmd          (cmd),
    .stat         (stat),
    .in_cell_row  (in_ch.cell_row),
    .in_cell_col  (in_ch.cell_col),
    .in_is_wall   (in_ch.is_wall),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_found    (out_ch.found),
    .out_path_row (out_ch.path_row),
    .out_path_col (out_ch.path_col),
    .out_last     (out_ch.last)
  );

endmodule
`default_nettype wire
